// File: design/sdq_pkg.sv
// Shared types, constants and helpers for the searchable deque.
// Used by sdq_ctrl, sdq_dpath and searchable_deque; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package sdq_pkg;

	localparam int DEPTH      = 16;
	localparam int ITEM_WIDTH = 32;
	localparam int WORD_WIDTH = 32;
	localparam int PTR_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W      = $clog2(DEPTH + 1);
	localparam int SUM_W      = PTR_W + 1;

	typedef logic [ITEM_WIDTH-1:0] item_t;
	typedef logic [WORD_WIDTH-1:0] word_t;
	typedef logic [PTR_W-1:0]      ptr_t;
	typedef logic [CNT_W-1:0]      cnt_t;
	typedef logic [2:0]            req_t;

	localparam req_t REQ_PUSH_FRONT = 3'd0;
	localparam req_t REQ_POP_FRONT  = 3'd1;
	localparam req_t REQ_PUSH_BACK  = 3'd2;
	localparam req_t REQ_POP_BACK   = 3'd3;
	localparam req_t REQ_CONTAINS   = 3'd4;
	localparam req_t REQ_REMOVE     = 3'd5;

	// Commands from the controller, one cycle each.
	typedef struct packed {
		logic load;
		logic push_front;
		logic push_back;
		logic pop_front;
		logic pop_back;
		logic cap_pop;
		logic set_err;
		logic set_found;
		logic idx_clr;
		logic idx_inc;
		logic scan_rd;
		logic shift_rd;
		logic shift_wr;
		logic count_dec;
		logic out_load;
	} dp_cmd_t;

	// Status back to the controller.
	typedef struct packed {
		req_t req;
		logic full;
		logic empty;
		logic list_valid;
		logic idx_at_end;
		logic idx_last;
		logic match;
		logic out_free;
	} dp_status_t;

	// Ring-buffer address add, both operands below DEPTH.
	function automatic ptr_t wrap_add(input ptr_t a, input ptr_t b);
		logic [SUM_W-1:0] sum;
		sum = {1'b0, a} + {1'b0, b};
		if (sum >= SUM_W'(DEPTH))
			sum = sum - SUM_W'(DEPTH);
		return sum[PTR_W-1:0];
	endfunction

	function automatic ptr_t ptr_dec(input ptr_t a);
		ptr_t r;
		if (a == '0)
			r = PTR_W'(DEPTH - 1);
		else
			r = a - PTR_W'(1);
		return r;
	endfunction

	function automatic item_t to_item(input word_t w);
		logic [63:0] ext;
		ext = 64'(w);
		return ext[ITEM_WIDTH-1:0];
	endfunction

	function automatic word_t to_word(input item_t v);
		logic [63:0] ext;
		ext = 64'(v);
		return ext[WORD_WIDTH-1:0];
	endfunction

endpackage

`default_nettype wire

// File: design/searchable_deque.sv
// Top level of the searchable deque: controller plus datapath.
// Depends on sdq_pkg, sdq_ctrl and sdq_dpath.
`timescale 1ns / 1ps
`default_nettype none

//  channel  | signals                                   | handshake
//  ---------+-------------------------------------------+------------------------
//  in       | req_type, item_value                      | in_valid / in_stall
//  out      | popped_value, found, error                | out_valid / out_stall
//  cfg      | cfg_data (list_valid)                     | cfg_valid / cfg_ready
//
// One request in flight at a time. Push: decode, then the result word is loaded.
// Pop: decode with the read, capture, then the result. Contains: a read state and a
// compare state per entry compared (up to DEPTH), then the result.
// Remove: the same search, then a read and a write state per entry behind the match
// to move it down; the entry memory has one read port and one write port.
// Reset clears count, head and output valid, and sets list_valid; the entry
// memory is not cleared. A stalled result holds in the output register while
// the next word is taken in and worked on.

module searchable_deque (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [2:0]  req_type,
	input  wire logic [31:0] item_value,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [31:0]      popped_value,
	output logic             found,
	output logic             error,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_data
);
	import sdq_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	// The user must make config writes land only while idle; the block does not enforce this and always takes them.
	assign cfg_ready = 1'b1;

	// Sequencer: decode, pop, scan, shift, hand off the result.
	sdq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	// Entries, pointers, compare and output register.
	sdq_dpath u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_type     (req_type),
		.item_value   (item_value),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.out_stall    (out_stall),
		.out_valid    (out_valid),
		.popped_value (popped_value),
		.found        (found),
		.error        (error),
		.cmd          (cmd),
		.status       (status)
	);

endmodule

`default_nettype wire

// File: design/sdq_ctrl.sv
// Sequencer for the searchable deque: decodes a request and steps the datapath.
// Depends on sdq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sdq_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire sdq_pkg::dp_status_t status,
	output sdq_pkg::dp_cmd_t         cmd
);
	import sdq_pkg::*;

	localparam logic [2:0] S_IDLE     = 3'd0;
	localparam logic [2:0] S_DECODE   = 3'd1;
	localparam logic [2:0] S_POP      = 3'd2;
	localparam logic [2:0] S_SCAN_RD  = 3'd3;
	localparam logic [2:0] S_SCAN_CMP = 3'd4;
	localparam logic [2:0] S_SHIFT_RD = 3'd5;
	localparam logic [2:0] S_SHIFT_WR = 3'd6;
	localparam logic [2:0] S_DONE     = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_DECODE;
				end
			end
			S_DECODE: begin
				state_d = S_DONE;
				unique case (status.req)
					REQ_PUSH_FRONT: begin
						if (status.full) cmd.set_err = 1'b1;
						else cmd.push_front = 1'b1;
					end
					REQ_PUSH_BACK: begin
						if (status.full) cmd.set_err = 1'b1;
						else cmd.push_back = 1'b1;
					end
					REQ_POP_FRONT: begin
						if (status.empty) begin
							cmd.set_err = 1'b1;
						end else begin
							cmd.pop_front = 1'b1;
							state_d       = S_POP;
						end
					end
					REQ_POP_BACK: begin
						if (status.empty) begin
							cmd.set_err = 1'b1;
						end else begin
							cmd.pop_back = 1'b1;
							state_d      = S_POP;
						end
					end
					REQ_CONTAINS: begin
						if (!status.list_valid) begin
							cmd.set_err = 1'b1;
						end else begin
							cmd.idx_clr = 1'b1;
							state_d     = S_SCAN_RD;
						end
					end
					REQ_REMOVE: begin
						if (!status.list_valid || status.empty) begin
							cmd.set_err = 1'b1;
						end else begin
							cmd.idx_clr = 1'b1;
							state_d     = S_SCAN_RD;
						end
					end
					default: begin
						// unused codes: all-zero result
					end
				endcase
			end
			S_POP: begin
				cmd.cap_pop = 1'b1;
				state_d     = S_DONE;
			end
			S_SCAN_RD: begin
				if (status.idx_at_end) begin
					if (status.req == REQ_REMOVE) cmd.set_err = 1'b1;
					state_d = S_DONE;
				end else begin
					cmd.scan_rd = 1'b1;
					state_d     = S_SCAN_CMP;
				end
			end
			S_SCAN_CMP: begin
				if (status.match) begin
					if (status.req == REQ_CONTAINS) begin
						cmd.set_found = 1'b1;
						state_d       = S_DONE;
					end else begin
						state_d = S_SHIFT_RD;
					end
				end else begin
					cmd.idx_inc = 1'b1;
					state_d     = S_SCAN_RD;
				end
			end
			S_SHIFT_RD: begin
				if (status.idx_last) begin
					cmd.count_dec = 1'b1;
					state_d       = S_DONE;
				end else begin
					cmd.shift_rd = 1'b1;
					state_d      = S_SHIFT_WR;
				end
			end
			S_SHIFT_WR: begin
				cmd.shift_wr = 1'b1;
				cmd.idx_inc  = 1'b1;
				state_d      = S_SHIFT_RD;
			end
			S_DONE: begin
				if (status.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

// File: design/sdq_dpath.sv
// Datapath of the searchable deque: ring-buffer memory, head and count,
// scan index, result and output registers, config register. Depends on sdq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sdq_dpath (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic [2:0]          req_type,
	input  wire logic [31:0]         item_value,
	input  wire logic                cfg_valid,
	input  wire logic                cfg_ready,
	input  wire logic                cfg_data,
	input  wire logic                out_stall,
	output logic                     out_valid,
	output logic [31:0]              popped_value,
	output logic                     found,
	output logic                     error,
	input  wire sdq_pkg::dp_cmd_t    cmd,
	output sdq_pkg::dp_status_t      status
);
	import sdq_pkg::*;

	item_t mem_q [DEPTH];
	item_t rd_data_q;
	ptr_t  head_q;
	cnt_t  count_q;
	cnt_t  idx_q;
	req_t  req_q;
	item_t item_q;
	logic  list_valid_q;
	item_t res_popped_q;
	logic  res_found_q;
	logic  res_err_q;
	word_t out_popped_q;
	logic  out_found_q;
	logic  out_err_q;
	logic  out_valid_q;

	ptr_t  rd_addr;
	ptr_t  wr_addr;
	item_t wr_data;
	logic  rd_en;
	logic  wr_en;
	ptr_t  cnt_ptr;
	ptr_t  idx_ptr;
	cnt_t  idx_next;

	assign cnt_ptr  = count_q[PTR_W-1:0];
	assign idx_ptr  = idx_q[PTR_W-1:0];
	assign idx_next = idx_q + CNT_W'(1);

	// Address selection for the single read and single write port.
	always_comb begin
		rd_en   = cmd.pop_front | cmd.pop_back | cmd.scan_rd | cmd.shift_rd;
		rd_addr = head_q;
		if (cmd.pop_back)
			rd_addr = wrap_add(head_q, cnt_ptr - PTR_W'(1));
		else if (cmd.scan_rd)
			rd_addr = wrap_add(head_q, idx_ptr);
		else if (cmd.shift_rd)
			rd_addr = wrap_add(head_q, idx_next[PTR_W-1:0]);

		wr_en   = cmd.push_front | cmd.push_back | cmd.shift_wr;
		wr_addr = wrap_add(head_q, idx_ptr);
		wr_data = rd_data_q;
		if (cmd.push_front) begin
			wr_addr = ptr_dec(head_q);
			wr_data = item_q;
		end else if (cmd.push_back) begin
			wr_addr = wrap_add(head_q, cnt_ptr);
			wr_data = item_q;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			mem_q[wr_addr] <= wr_data;
	end

	always_ff @(posedge clk) begin
		if (rd_en)
			rd_data_q <= mem_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q       <= '0;
			count_q      <= '0;
			list_valid_q <= 1'b1;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready)
				list_valid_q <= cfg_data;
			if (cmd.push_front)
				head_q <= ptr_dec(head_q);
			else if (cmd.pop_front)
				head_q <= wrap_add(head_q, PTR_W'(1));
			if (cmd.push_front || cmd.push_back)
				count_q <= count_q + CNT_W'(1);
			else if (cmd.pop_front || cmd.pop_back || cmd.count_dec)
				count_q <= count_q - CNT_W'(1);
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q        <= req_type;
			item_q       <= to_item(item_value);
			res_popped_q <= '0;
			res_found_q  <= 1'b0;
			res_err_q    <= 1'b0;
		end
		if (cmd.cap_pop)   res_popped_q <= rd_data_q;
		if (cmd.set_found) res_found_q  <= 1'b1;
		if (cmd.set_err)   res_err_q    <= 1'b1;
		if (cmd.idx_clr)
			idx_q <= '0;
		else if (cmd.idx_inc)
			idx_q <= idx_next;
		if (cmd.out_load) begin
			out_popped_q <= to_word(res_popped_q);
			out_found_q  <= res_found_q;
			out_err_q    <= res_err_q;
		end
	end

	assign status.req        = req_q;
	assign status.full       = (count_q == CNT_W'(DEPTH));
	assign status.empty      = (count_q == '0);
	assign status.list_valid = list_valid_q;
	assign status.idx_at_end = (idx_q == count_q);
	assign status.idx_last   = (idx_next == count_q);
	assign status.match      = (rd_data_q == item_q);
	assign status.out_free   = !out_valid_q || !out_stall;

	assign out_valid    = out_valid_q;
	assign popped_value = out_popped_q;
	assign found        = out_found_q;
	assign error        = out_err_q;

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("entry count above depth");
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.push_front || cmd.push_back) |-> !status.full)
		else $error("push issued on a full list");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.pop_front || cmd.pop_back || cmd.count_dec) |-> !status.empty)
		else $error("removal issued on an empty list");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || !out_stall))
		else $error("result overwrote a stalled word");
`endif

endmodule

`default_nettype wire

// File: test/tb_searchable_deque.sv
// Testbench for searchable_deque: directed and random request traffic,
// checked word by word against a behavioral deque held in the bench.
// Depends on sdq_pkg and searchable_deque.
`timescale 1ns / 1ps

module tb_searchable_deque;
	import sdq_pkg::*;

	// Request codes that the block treats as no-ops.
	localparam req_t REQ_NOP_LO = 3'd6;
	localparam req_t REQ_NOP_HI = 3'd7;

	// Slowest request is a remove that scans and shifts the whole list,
	// plus the longest stall burst and the longest send gap.
	// Allow many times that with no word moving on any channel.
	localparam int QUIET_LIMIT = 2000;
	localparam int TAIL_CYCLES = 80;

	typedef struct packed {
		word_t popped;
		logic  found;
		logic  error;
	} deque_result_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [2:0]  req_type;
	logic [31:0] item_value;
	logic        out_valid;
	logic        out_stall;
	logic [31:0] popped_value;
	logic        found;
	logic        error;
	logic        cfg_valid;
	logic        cfg_ready;
	logic        cfg_data;

	// Bench copy of the deque: front at index 0.
	item_t         deque_model[$];
	bit            list_valid_model;
	deque_result_t pending_results[$];

	bit idle_on;
	int failures;
	int words_sent;
	int results_seen;
	int full_rejects;
	int search_hits;
	int peak_fill;
	int cfg_writes;

	searchable_deque dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.req_type     (req_type),
		.item_value   (item_value),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.popped_value (popped_value),
		.found        (found),
		.error        (error),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Apply one accepted request to the bench deque and return the result
	// word it must produce.
	function automatic deque_result_t deque_response(req_t req, item_t value);
		deque_result_t res;
		int hit;
		int i;
		res = '0;
		hit = -1;
		case (req)
			REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
				if (deque_model.size() >= DEPTH) begin
					res.error = 1'b1;
					full_rejects++;
				end else if (req == REQ_PUSH_FRONT) begin
					deque_model.push_front(value);
				end else begin
					deque_model.push_back(value);
				end
			end
			REQ_POP_FRONT, REQ_POP_BACK: begin
				if (deque_model.size() == 0)
					res.error = 1'b1;
				else if (req == REQ_POP_FRONT)
					res.popped = word_t'(deque_model.pop_front());
				else
					res.popped = word_t'(deque_model.pop_back());
			end
			REQ_CONTAINS, REQ_REMOVE: begin
				// Search from the front; an invalid list rejects both.
				for (i = 0; i < deque_model.size(); i++)
					if (hit < 0 && deque_model[i] == value)
						hit = i;
				if (!list_valid_model || hit < 0) begin
					res.error = (req == REQ_REMOVE) || !list_valid_model;
				end else if (req == REQ_CONTAINS) begin
					res.found = 1'b1;
					search_hits++;
				end else begin
					deque_model.delete(hit);
					search_hits++;
				end
			end
			default: ;
		endcase
		if (deque_model.size() > peak_fill)
			peak_fill = deque_model.size();
		return res;
	endfunction

	// Mostly values already in the list so searches and removes hit;
	// the rest small values (likely repeats) or fully random words.
	function automatic item_t pick_value();
		if (deque_model.size() != 0 && $urandom_range(0, 9) < 6)
			return deque_model[$urandom_range(0, deque_model.size() - 1)];
		if ($urandom_range(0, 1) == 1)
			return item_t'($urandom_range(0, 15));
		return item_t'($urandom());
	endfunction

	// Entered and left just after a falling edge. Valid stays high on
	// return so back-to-back words need no low cycle.
	task automatic send_request(req_t req, item_t value);
		if (idle_on && $urandom_range(0, 4) == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		in_valid   = 1'b1;
		req_type   = req;
		item_value = value;
		do
			@(posedge clk);
		while (in_stall);
		pending_results.push_back(deque_response(req, value));
		words_sent++;
		@(negedge clk);
	endtask

	// Drop valid and hold until every predicted result has come out.
	task automatic drain_results();
		in_valid = 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
	endtask

	// Write list_valid only with the block idle.
	task automatic write_list_valid(bit value);
		drain_results();
		cfg_valid = 1'b1;
		cfg_data  = value;
		do
			@(posedge clk);
		while (!cfg_ready);
		list_valid_model = value;
		cfg_writes++;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Empty-list errors, extreme values, both ends, no-op codes.
	task automatic test_empty_and_edges();
		send_request(REQ_POP_FRONT, '0);
		send_request(REQ_POP_BACK, '1);
		send_request(REQ_REMOVE, '0);
		send_request(REQ_CONTAINS, '0);
		send_request(REQ_NOP_LO, '1);
		send_request(REQ_NOP_HI, 32'h5a5a_a5a5);
		send_request(REQ_PUSH_FRONT, '0);
		send_request(REQ_PUSH_BACK, '1);
		send_request(REQ_CONTAINS, '1);
		send_request(REQ_CONTAINS, 32'h0000_1234);
		send_request(REQ_REMOVE, 32'h0000_1234);
		send_request(REQ_NOP_HI, '0);
		send_request(REQ_POP_FRONT, 32'hffff_0000);
		send_request(REQ_POP_BACK, 32'h0000_ffff);
	endtask

	// With list_valid clear, searches fail while pushes and pops still work.
	task automatic test_invalid_list();
		write_list_valid(1'b0);
		send_request(REQ_CONTAINS, 32'h0000_0005);
		send_request(REQ_PUSH_BACK, 32'h0000_0005);
		send_request(REQ_CONTAINS, 32'h0000_0005);
		send_request(REQ_REMOVE, 32'h0000_0005);
		send_request(REQ_POP_BACK, '0);
		send_request(REQ_REMOVE, 32'h0000_0005);
		write_list_valid(1'b1);
	endtask

	// Fill to DEPTH, overflow both ends, search at the far end, remove from
	// the middle with duplicates present, then empty the list.
	task automatic test_full_list();
		item_t probe;
		while (deque_model.size() < DEPTH)
			send_request($urandom_range(0, 1) ? REQ_PUSH_FRONT : REQ_PUSH_BACK,
				item_t'($urandom_range(0, 7)));
		send_request(REQ_PUSH_FRONT, '1);
		send_request(REQ_PUSH_BACK, '0);
		probe = deque_model[DEPTH - 1];
		send_request(REQ_CONTAINS, probe);
		send_request(REQ_REMOVE, deque_model[DEPTH / 2]);
		send_request(REQ_REMOVE, 32'hdead_beef);
		send_request(REQ_PUSH_BACK, '1);
		send_request(REQ_REMOVE, '1);
		while (deque_model.size() != 0)
			send_request($urandom_range(0, 1) ? REQ_POP_FRONT : REQ_POP_BACK,
				item_t'($urandom()));
		send_request(REQ_POP_FRONT, '0);
	endtask

	// Random requests; push_pct steers the list toward full or empty.
	task automatic test_random_traffic(int count, int push_pct);
		req_t req;
		int roll;
		for (int n = 0; n < count; n++) begin
			roll = $urandom_range(0, 99);
			if (roll < 2)
				req = req_t'($urandom_range(REQ_NOP_LO, REQ_NOP_HI));
			else if (roll < 2 + push_pct)
				req = $urandom_range(0, 1) ? REQ_PUSH_FRONT : REQ_PUSH_BACK;
			else
				case ($urandom_range(0, 3))
					0: req = REQ_POP_FRONT;
					1: req = REQ_POP_BACK;
					2: req = REQ_CONTAINS;
					default: req = REQ_REMOVE;
				endcase
			send_request(req, pick_value());
			// Now and then hold the sender until the block has caught up.
			if (idle_on && $urandom_range(0, 49) == 0)
				drain_results();
		end
	endtask

	// Last stretch at full rate: no send gaps and no output stalls.
	task automatic test_quiet_tail();
		drain_results();
		idle_on = 1'b0;
		test_random_traffic(200, 45);
	endtask

	// Drive the receiver side: stall in random bursts while idle_on is set.
	initial begin : stall_driver
		int stall_left;
		stall_left = 0;
		out_stall  = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left == 0 && idle_on && $urandom_range(0, 5) == 0)
				stall_left = $urandom_range(1, 4);
			out_stall = (stall_left != 0);
			if (stall_left != 0)
				stall_left--;
		end
	end

	// Check each accepted result word against the oldest prediction.
	always @(posedge clk) begin : result_check
		deque_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				$error("result word with none expected: popped_value %h found %b error %b",
					popped_value, found, error);
				failures++;
			end else begin
				want = pending_results.pop_front();
				if (popped_value !== want.popped) begin
					$error("popped_value: expected %h, got %h", want.popped, popped_value);
					failures++;
				end
				if (found !== want.found) begin
					$error("found: expected %b, got %b", want.found, found);
					failures++;
				end
				if (error !== want.error) begin
					$error("error: expected %b, got %b", want.error, error);
					failures++;
				end
			end
		end
	end

	// End the run if no word moves on any channel for too long.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
					(cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		arst_n           = 1'b0;
		in_valid         = 1'b0;
		req_type         = REQ_PUSH_FRONT;
		item_value       = '0;
		cfg_valid        = 1'b0;
		cfg_data         = 1'b1;
		list_valid_model = 1'b1;
		idle_on          = 1'b1;
		failures         = 0;
		words_sent       = 0;
		results_seen     = 0;
		full_rejects     = 0;
		search_hits      = 0;
		peak_fill        = 0;
		cfg_writes       = 0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Set the register explicitly once, even though reset already does.
		write_list_valid(1'b1);
		test_empty_and_edges();
		test_invalid_list();
		test_full_list();

		test_random_traffic(300, 45);
		test_random_traffic(250, 70);
		test_random_traffic(250, 25);
		drain_results();
		write_list_valid(1'b0);
		test_random_traffic(200, 50);
		write_list_valid(1'b1);
		test_random_traffic(300, 45);
		test_random_traffic(200, 65);
		test_quiet_tail();

		// Wait out every result, then watch for stray words.
		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Sent %0d requests, checked %0d results; %0d full-list rejects, %0d hits.",
			words_sent, results_seen, full_rejects, search_hits);
		$display("Peak fill %0d of %0d entries, %0d list_valid writes.",
			peak_fill, DEPTH, cfg_writes);
		if (failures == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// File: searchable_deque.f
design/sdq_pkg.sv
design/sdq_ctrl.sv
design/sdq_dpath.sv
design/searchable_deque.sv
test/tb_searchable_deque.sv
